@@ rtl/tcw_pkg.sv @@
// Shared types, constants and helper functions of the tick clock with weekday.
`timescale 1ns / 1ps

package tcw_pkg;

   // Field widths
   localparam int unsigned YEAR_W    = 7;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned TICKS_W   = 16;
   localparam int unsigned HOURS_W   = 5;
   localparam int unsigned MINUTES_W = 6;
   localparam int unsigned SECONDS_W = 6;
   localparam int unsigned DAY_W     = 8;
   localparam int unsigned WEEKDAY_W = 3;

   // Stream and register port widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_YEAR  = 2'd0;
   localparam logic [1:0] REG_MONTH = 2'd1;
   localparam logic [1:0] REG_TICKS = 2'd2;

   // Register reset values
   localparam logic [YEAR_W-1:0]  YEAR_RESET  = 7'd19;
   localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd5;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;

   // Counter limits and reset values
   localparam logic [SECONDS_W-1:0] MAX_SECOND   = 6'd59;
   localparam logic [MINUTES_W-1:0] MAX_MINUTE   = 6'd59;
   localparam logic [HOURS_W-1:0]   MAX_HOUR     = 5'd23;
   localparam logic [HOURS_W-1:0]   HOUR_RESET   = 5'd12;
   localparam logic [DAY_W-1:0]     DAY_RESET    = 8'd1;
   localparam logic [YEAR_W-1:0]    YEARS_PER_CENTURY = 7'd100;
   localparam logic [7:0]           CENTURY_BIAS = 8'd100;
   localparam logic [MONTH_W-1:0]   MARCH        = 4'd3;
   localparam logic [WEEKDAY_W-1:0] SUNDAY       = 3'd6;

   // Time of day after an update
   typedef struct packed {
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
      logic [SECONDS_W-1:0] seconds;
      logic [DAY_W-1:0]     day;
   } time_type;

   // Counter chain status toward the result path
   typedef struct packed {
      logic     done;
      time_type now;
   } count_status_type;

   // Day offset of each month, 0 for codes that name no month
   function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [2:0] off;
      case (month)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd3;
         4'd4:    off = 3'd6;
         4'd5:    off = 3'd1;
         4'd6:    off = 3'd4;
         4'd7:    off = 3'd6;
         4'd8:    off = 3'd2;
         4'd9:    off = 3'd5;
         4'd10:   off = 3'd0;
         4'd11:   off = 3'd3;
         4'd12:   off = 3'd5;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   // Residue modulo 7 of a 9-bit value: fold octal digits, since 8 = 1 mod 7
   function automatic logic [2:0] mod7(input logic [8:0] x);
      logic [4:0] s;
      logic [3:0] s2;
      s  = {2'b00, x[8:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
      s2 = {2'b00, s[4:3]} + {1'b0, s[2:0]};
      if (s2 >= 4'd7) begin
         s2 = s2 - 4'd7;
      end
      return s2[2:0];
   endfunction

endpackage

@@ rtl/tcw_counter.sv @@
// Millisecond tick counter and seconds / minutes / hours / day chain.
`timescale 1ns / 1ps

module tcw_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_accept,
   input  logic [tcw_pkg::TICKS_W-1:0]   ticks_per_second,
   output tcw_pkg::count_status_type     status
);
   import tcw_pkg::*;

   logic [TICKS_W-1:0]   millis_ff,  millis_in;
   logic [SECONDS_W-1:0] second_ff,  second_in;
   logic [MINUTES_W-1:0] minute_ff,  minute_in;
   logic [HOURS_W-1:0]   hour_ff,    hour_in;
   logic [DAY_W-1:0]     day_ff,     day_in;
   logic [TICKS_W-1:0]   millis_plus;
   logic [SECONDS_W-1:0] second_plus;
   logic [MINUTES_W-1:0] minute_plus;
   logic [HOURS_W-1:0]   hour_plus;
   logic                 second_done;

   // Count the tick and carry through the chain when a second completes
   always_comb begin
      millis_plus = millis_ff + 1'b1;
      second_done = (millis_plus >= ticks_per_second);
      second_plus = second_ff + 1'b1;
      minute_plus = minute_ff + 1'b1;
      hour_plus   = hour_ff + 1'b1;

      millis_in = millis_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;

      if (tick_accept) begin
         millis_in = millis_plus;
         if (second_done) begin
            millis_in = '0;
            second_in = second_plus;
            if (second_plus > MAX_SECOND) begin
               second_in = '0;
               minute_in = minute_plus;
               if (minute_plus > MAX_MINUTE) begin
                  minute_in = '0;
                  hour_in   = hour_plus;
                  if (hour_plus > MAX_HOUR) begin
                     hour_in = '0;
                     day_in  = day_ff + 1'b1;
                  end
               end
            end
         end
      end
   end

   // Hold the clock state
   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff <= '0;
         second_ff <= '0;
         minute_ff <= '0;
         hour_ff   <= HOUR_RESET;
         day_ff    <= DAY_RESET;
      end else begin
         millis_ff <= millis_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
         day_ff    <= day_in;
      end
   end

   // Report the updated time of day
   assign status.done        = tick_accept & second_done;
   assign status.now.hours   = hour_in;
   assign status.now.minutes = minute_in;
   assign status.now.seconds = second_in;
   assign status.now.day     = day_in;

endmodule

@@ rtl/tcw_weekday.sv @@
// Weekday from year of century, month and day by a table-based congruence.
`timescale 1ns / 1ps

module tcw_weekday (
   input  logic [tcw_pkg::YEAR_W-1:0]    year,
   input  logic [tcw_pkg::MONTH_W-1:0]   month,
   input  logic [tcw_pkg::DAY_W-1:0]     day,
   output logic [tcw_pkg::WEEKDAY_W-1:0] weekday
);
   import tcw_pkg::*;

   logic [7:0] full_year;
   logic [8:0] year_sum;
   logic [2:0] year_term;
   logic [8:0] base_sum;
   logic [8:0] total;
   logic [2:0] residue;
   logic       leap_adjust;

   always_comb begin
      // Fold years past the century back and add the century bias
      if (year < YEARS_PER_CENTURY) begin
         full_year = {1'b0, year} + CENTURY_BIAS;
      end else begin
         full_year = {1'b0, year};
      end
      year_sum  = {1'b0, full_year} + {3'b000, full_year[7:2]};
      year_term = mod7(year_sum);

      // Leap years step January, February and the invalid month zero back one day
      leap_adjust = (year[1:0] == 2'b00) && (month < MARCH);
      base_sum    = {6'd0, year_term} + {1'b0, day} + {6'd0, month_offset(month)};
      // Minus one is plus six modulo 7
      total       = base_sum + (leap_adjust ? 9'd6 : 9'd0);
      residue     = mod7(total);
      // Stepping back from zero wraps the 16-bit sum to 65535, residue one
      if (leap_adjust && (base_sum == 9'd0)) begin
         residue = 3'd1;
      end

      // Residue 0 is Sunday, others count up from Monday
      weekday = (residue == 3'd0) ? SUNDAY : residue - 3'd1;
   end

endmodule

@@ rtl/tick_clock_with_weekday_unit.sv @@
// Top level of the tick clock with weekday: register port, counters, result buffer.
//
// Input stream (req_*): one transfer per millisecond tick, tdata[0] = tick.
// A transfer with tick 0 changes nothing. A tick transfer counts toward
// ticks_per_second; when the count is reached one second is added to the
// seconds / minutes / hours / day chain and one result transfer follows.
// Output stream (rsp_*): hours, minutes, seconds, day and weekday of the
// updated time, one transfer per completed second.
// A completed second's result is registered into the output register, or into
// the skid entry while the receiver stalls. Throughput: one input transfer per
// cycle while req_tready is high; the two-entry result buffer (output register
// plus skid entry) takes one more result while the receiver stalls, and
// req_tready drops only while both entries hold results.
// Registers (csr_*): 0x0 year of century, 0x4 month, 0x8 ticks per second.
// Write them only while no result is pending.
// Reset: time becomes 12:00:00 on day 1, registers return to 19 / 5 / 1000,
// the result buffer empties.
`timescale 1ns / 1ps

module tick_clock_with_weekday_unit (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: tick [0], zero fill [7:1]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tdata: hours [4:0], minutes [10:5], seconds [16:11], day_of_month [24:17],
   //        weekday [27:25], zero fill [31:28]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import tcw_pkg::*;

   logic [YEAR_W-1:0]     year_ff;
   logic [MONTH_W-1:0]    month_ff;
   logic [TICKS_W-1:0]    ticks_ff;
   logic                  csr_write;
   logic [1:0]            csr_index;
   logic                  tick_accept;
   count_status_type      status;
   logic [WEEKDAY_W-1:0]  weekday;
   logic [RSP_DATA_W-1:0] result;
   logic                  push;
   logic                  pop;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff,  out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0] skid_data_ff,  skid_data_in;

   // Register port: write on the access cycle, read back zero extended
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= YEAR_RESET;
         month_ff <= MONTH_RESET;
         ticks_ff <= TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_YEAR:  year_ff  <= csr_pwdata[YEAR_W-1:0];
            REG_MONTH: month_ff <= csr_pwdata[MONTH_W-1:0];
            REG_TICKS: ticks_ff <= csr_pwdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_YEAR:  csr_prdata = {{(CSR_DATA_W-YEAR_W){1'b0}}, year_ff};
         REG_MONTH: csr_prdata = {{(CSR_DATA_W-MONTH_W){1'b0}}, month_ff};
         REG_TICKS: csr_prdata = {{(CSR_DATA_W-TICKS_W){1'b0}}, ticks_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Counter chain and weekday
   assign tick_accept = req_tvalid & req_tready & req_tdata[0];

   tcw_counter u_counter (
      .clock            (clock),
      .reset            (reset),
      .tick_accept      (tick_accept),
      .ticks_per_second (ticks_ff),
      .status           (status)
   );

   tcw_weekday u_weekday (
      .year    (year_ff),
      .month   (month_ff),
      .day     (status.now.day),
      .weekday (weekday)
   );

   assign result = {{(RSP_DATA_W-28){1'b0}}, weekday, status.now.day,
                    status.now.seconds, status.now.minutes, status.now.hours};

   // Result buffer: output register with one skid entry behind it
   assign push       = status.done;
   assign pop        = out_valid_ff & rsp_tready;
   assign req_tready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // Advance the skid entry, park a new result behind it
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = result;
         end else begin
            out_valid_in = push;
            out_data_in  = result;
         end
      end else if (push) begin
         // Receiver stalls: hold the head, drop the new result into the skid
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // The skid entry is only ever filled behind a waiting head
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without head entry");

   // No result is produced while the buffer is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result produced with full buffer");

   // A result into an empty buffer shows at the output in the next cycle
   a_direct_result: assert property (@(posedge clock) disable iff (reset)
      push && !out_valid_ff |=> rsp_tvalid && (rsp_tdata == $past(result)))
      else $error("result not presented after completed second");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the tick clock with weekday: stimulus, scoreboard and checks.
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam logic [1:0]  REG_SPARE   = 2'd3;

   // One expected clock reading, in the order of the result fields
   typedef struct {
      logic [HOURS_W-1:0]   hours;
      logic [MINUTES_W-1:0] minutes;
      logic [SECONDS_W-1:0] seconds;
      logic [DAY_W-1:0]     day;
      logic [WEEKDAY_W-1:0] weekday;
   } clock_reading_type;

   // Shadow clock: registers, counter chain and the readings still owed by the block
   class rtc_scoreboard;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [TICKS_W-1:0]   period;
      logic [TICKS_W-1:0]   millis;
      logic [SECONDS_W-1:0] sec_count;
      logic [MINUTES_W-1:0] min_count;
      logic [HOURS_W-1:0]   hour_count;
      logic [DAY_W-1:0]     day_count;
      clock_reading_type    readings[$];
      int unsigned          errors;

      function new();
         year       = YEAR_RESET;
         month      = MONTH_RESET;
         period     = TICKS_RESET;
         millis     = '0;
         sec_count  = '0;
         min_count  = '0;
         hour_count = HOUR_RESET;
         day_count  = DAY_RESET;
         errors     = 0;
      endfunction

      function void report(string field, longint got, longint want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
         errors++;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_YEAR:  year   = value[YEAR_W-1:0];
            REG_MONTH: month  = value[MONTH_W-1:0];
            REG_TICKS: period = value[TICKS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_YEAR:  return 32'(year);
            REG_MONTH: return 32'(month);
            REG_TICKS: return 32'(period);
            default:   return '0;
         endcase
      endfunction

      // Day shift of each month; codes that name no month shift by nothing
      function int unsigned month_shift(logic [MONTH_W-1:0] m);
         case (m)
            4'd2, 4'd3, 4'd11: return 3;
            4'd4, 4'd7:        return 6;
            4'd5:              return 1;
            4'd6:              return 4;
            4'd8:              return 2;
            4'd9, 4'd12:       return 5;
            default:           return 0;
         endcase
      endfunction

      // Congruence over the years 2000..2127, folded to 100..199 like the block does
      function logic [WEEKDAY_W-1:0] weekday_now();
         int unsigned yy;
         int unsigned t;
         yy = (int'(year) + 2000) % 100 + 100;
         t  = ((yy + yy / 4) % 7 + int'(day_count) + month_shift(month)) & 32'hFFFF;
         // leap years borrow one day in January, February and the invalid month zero
         if (yy % 4 == 0 && month < MARCH) begin
            t = (t - 1) & 32'hFFFF;
         end
         t = t % 7;
         return (t == 0) ? SUNDAY : WEEKDAY_W'(t - 1);
      endfunction

      // Advance on a tick transfer; queue a reading when a second completes
      function void note_tick(logic tick);
         clock_reading_type r;
         if (!tick) return;
         millis = millis + 1'b1;
         if (millis < period) return;
         millis = '0;
         if (sec_count == MAX_SECOND) begin
            sec_count = '0;
            if (min_count == MAX_MINUTE) begin
               min_count = '0;
               if (hour_count == MAX_HOUR) begin
                  hour_count = '0;
                  day_count  = day_count + 1'b1;
               end else begin
                  hour_count = hour_count + 1'b1;
               end
            end else begin
               min_count = min_count + 1'b1;
            end
         end else begin
            sec_count = sec_count + 1'b1;
         end
         r.hours   = hour_count;
         r.minutes = min_count;
         r.seconds = sec_count;
         r.day     = day_count;
         r.weekday = weekday_now();
         readings.push_back(r);
      endfunction

      // Compare a result transfer with the oldest reading owed
      function void check_reading(logic [RSP_DATA_W-1:0] data);
         clock_reading_type want;
         if (readings.size() == 0) begin
            report("result with none pending", data, 0);
            return;
         end
         want = readings.pop_front();
         if (data[4:0]   !== want.hours)   report("hours", data[4:0], want.hours);
         if (data[10:5]  !== want.minutes) report("minutes", data[10:5], want.minutes);
         if (data[16:11] !== want.seconds) report("seconds", data[16:11], want.seconds);
         if (data[24:17] !== want.day)     report("day_of_month", data[24:17], want.day);
         if (data[27:25] !== want.weekday) report("weekday", data[27:25], want.weekday);
         if (data[31:28] !== 4'b0)         report("zero fill", data[31:28], 0);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rtc_scoreboard sb;
   int unsigned   send_gap_pct = 6;
   int unsigned   recv_gap_pct = 46;
   int unsigned   cycles = 0;

   tick_clock_with_weekday_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: stall at random at the current rate
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Watch both streams at the clock edge and bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** tick_clock_with_weekday_unit: FAILED **");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_tick(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) sb.check_reading(rsp_tdata);
      end
   end

   // Register access: setup cycle, access cycle, then idle with psel low before returning
   task automatic csr_access(input logic [1:0] idx, input logic write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] ignored;
      csr_access(idx, 1'b1, value, ignored);
      sb.write_reg(idx, value);
   endtask

   task automatic check_regs();
      logic [31:0] got;
      for (int i = 0; i < 3; i++) begin
         csr_access(2'(i), 1'b0, '0, got);
         if (got !== sb.reg_value(2'(i))) sb.report("register readback", got,
                                                    sb.reg_value(2'(i)));
      end
   endtask

   task automatic configure(input logic [31:0] yr, input logic [31:0] mo,
                            input logic [31:0] per);
      write_csr(REG_YEAR, yr);
      write_csr(REG_MONTH, mo);
      write_csr(REG_TICKS, per);
      check_regs();
   endtask

   // Hold until every reading has arrived, then let the block settle
   task automatic wait_idle();
      while (sb.readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One tick transfer, with random idle cycles ahead of it
   task automatic send_tick(input logic tick);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, tick};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_pattern(input logic [3:0] bits, input int n);
      for (int i = 0; i < n; i++) send_tick(bits[i]);
      req_tvalid <= 1'b0;
      wait_idle();
   endtask

   // Send n ticks of one, with zero ticks mixed in at the given rate
   task automatic run_ticks(input int unsigned n, input int unsigned zero_pct);
      int unsigned sent;
      logic        tick;
      sent = 0;
      while (sent < n) begin
         tick = ($urandom_range(99) >= zero_pct);
         send_tick(tick);
         if (tick) sent++;
      end
      req_tvalid <= 1'b0;
      wait_idle();
   endtask

   // Rewrite some registers; periods are mostly short so seconds complete often
   task automatic random_config();
      logic [31:0] v;
      int unsigned p;
      if ($urandom_range(99) < 70) write_csr(REG_YEAR, $urandom);
      if ($urandom_range(99) < 70) write_csr(REG_MONTH, $urandom);
      if ($urandom_range(99) < 70) begin
         v = $urandom;
         p = $urandom_range(99);
         if (p < 60)      v[15:0] = 16'($urandom_range(0, 3));
         else if (p < 80) v[15:0] = 16'($urandom_range(4, 30));
         else if (p < 92) v[15:0] = 16'($urandom_range(31, 2000));
         else if (p < 96) v[15:0] = 16'hFFFF;
         else             v[15:0] = 16'($urandom_range(0, 65535));
         write_csr(REG_TICKS, v);
      end
      if ($urandom_range(99) < 10) write_csr(REG_SPARE, $urandom);
      check_regs();
   endtask

   initial begin
      int unsigned done;
      int unsigned n;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset values, zero and full periods, leap months, invalid months
      check_regs();
      configure(32'd0, 32'd1, 32'd0);
      send_pattern(4'b0110, 3);
      configure(32'd99, 32'd12, 32'd1);
      send_pattern(4'b0101, 3);
      configure(32'd100, 32'd2, 32'd0);
      send_pattern(4'b0001, 1);
      configure(32'd4, 32'd0, 32'd0);
      send_pattern(4'b0001, 1);
      configure(32'd127, 32'd15, 32'd0);
      send_pattern(4'b0001, 1);
      configure(32'd8, 32'd13, 32'd1);
      send_pattern(4'b0001, 1);
      // a write past the last register changes nothing
      write_csr(REG_SPARE, 32'hFFFF_FFFF);
      check_regs();
      send_pattern(4'b0001, 1);
      // lower the period below the running count: the next tick completes a second
      configure(32'd19, 32'd5, 32'hFFFF_FFFF);
      send_pattern(4'b0111, 3);
      write_csr(REG_TICKS, 32'd2);
      check_regs();
      send_pattern(4'b0001, 1);
      write_csr(REG_TICKS, 32'd3);
      check_regs();
      send_pattern(4'b0111, 3);

      // Random: sender idles lightly, then receiver lightly, then no idling
      for (int r = 0; r < 3; r++) begin
         send_gap_pct = (r == 0) ? 6 : (r == 1) ? 46 : 0;
         recv_gap_pct = (r == 0) ? 46 : (r == 1) ? 6 : 0;
         done = 0;
         while (done < 90) begin
            random_config();
            n = $urandom_range(8, 30);
            run_ticks(n, 15);
            done += n;
         end
      end

      // Run at one second per tick across the next minute boundary so the minute carry occurs
      configure($urandom, $urandom, 32'd0);
      n = 60 - int'(sb.sec_count) + 5;
      run_ticks(n, 0);
      random_config();
      run_ticks(20, 15);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.readings.size() == 0) begin
         $display("** tick_clock_with_weekday_unit: PASSED **");
      end else begin
         $display("** tick_clock_with_weekday_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tcw_pkg.sv
rtl/tcw_counter.sv
rtl/tcw_weekday.sv
rtl/tick_clock_with_weekday_unit.sv
tb/tb.sv
